>>> rtl/b32w_pkg.sv
package b32w_pkg;

  localparam int unsigned LINE_LEN_W      = 10;
  localparam int unsigned SYM_W           = 5;
  localparam int unsigned SYMS_PER_REQ    = 3;
  localparam int unsigned B32W_QUEUE_DEPTH = 4;

  localparam logic [7:0] CHAR_PAD = 8'h3D;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_A   = 8'h41;
  localparam logic [7:0] CHAR_TWO = 8'h32;

  // One classified byte: the symbols it produces (flush included) and its end mark.
  typedef struct packed {
    logic [SYMS_PER_REQ-1:0][SYM_W-1:0] syms;
    logic [1:0]                         nsym;
    logic                               last;
  } sym_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] sym_to_char(input logic [SYM_W-1:0] sym);
    logic [7:0] ch;
    if (sym < 5'd26) begin
      ch = CHAR_A + {3'd0, sym};
    end else begin
      ch = CHAR_TWO + {3'd0, sym - 5'd26};
    end
    return ch;
  endfunction

endpackage

>>> rtl/b32w_if.sv
interface b32w_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b32w_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;
  logic       message_end;

  modport source (output valid, output out_char, output run_last, output message_end,
                  input ready);
  modport sink   (input valid, input out_char, input run_last, input message_end,
                  output ready);
endinterface

>>> rtl/b32w_front.sv
module b32w_front
  import b32w_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  b32w_in_if.sink    in_if,
  input  q_status_t  q_status_i,
  output logic       push_o,
  output sym_req_t   req_o
);

  logic [3:0]  lo_bits_q;
  logic [2:0]  lo_cnt_q;

  logic [11:0] acc;
  logic [3:0]  total;
  logic        two;
  logic [2:0]  rem;
  logic [3:0]  lbits;
  logic [8:0]  flush_wide;
  logic [4:0]  sym0;
  logic [4:0]  sym1;
  logic [4:0]  flush;
  logic        has_flush;

  assign in_if.ready = !q_status_i.full;
  assign push_o      = in_if.valid && !q_status_i.full;

  always_comb begin
    acc        = {lo_bits_q, in_if.data_byte};
    total      = {1'b0, lo_cnt_q} + 4'd8;
    two        = (total >= 4'd10);
    sym0       = 5'(acc >> (total - 4'd5));
    sym1       = 5'(acc >> (total - 4'd10));
    rem        = two ? 3'(total - 4'd10) : 3'(total - 4'd5);
    lbits      = acc[3:0] & ((4'd1 << rem) - 4'd1);
    // left-align the leftover bits into one symbol, zero-filled
    flush_wide = {5'd0, lbits} << (3'd5 - rem);
    flush      = flush_wide[4:0];
    has_flush  = in_if.last_byte && (rem != 3'd0);

    req_o.syms[0] = sym0;
    req_o.syms[1] = two ? sym1 : flush;
    req_o.syms[2] = flush;
    req_o.nsym    = (two ? 2'd2 : 2'd1) + {1'b0, has_flush};
    req_o.last    = in_if.last_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_bits_q <= '0;
      lo_cnt_q  <= '0;
    end else if (push_o) begin
      lo_bits_q <= in_if.last_byte ? 4'd0 : lbits;
      lo_cnt_q  <= in_if.last_byte ? 3'd0 : rem;
    end
  end

endmodule

>>> rtl/b32w_queue.sv
module b32w_queue
  import b32w_pkg::*;
#(
  parameter int unsigned Depth = B32W_QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  sym_req_t  push_req_i,
  input  logic      pop_i,
  output sym_req_t  head_o,
  output q_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sym_req_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_pop;

  assign status_o.full  = (cnt_q == CntW'(Depth));
  assign status_o.empty = (cnt_q == '0);
  assign head_o         = mem_q[rd_ptr_q];
  assign do_pop         = pop_i && !status_o.empty;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] n;
    if (p == PtrW'(Depth - 1)) begin
      n = '0;
    end else begin
      n = p + PtrW'(1);
    end
    return n;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

>>> rtl/b32w_back.sv
module b32w_back
  import b32w_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [LINE_LEN_W-1:0] cfg_wdata_i,
  input  sym_req_t              head_i,
  input  q_status_t             q_status_i,
  output logic                  pop_o,
  b32w_out_if.source            out_if
);

  typedef enum logic [1:0] {
    MODE_ENC,
    MODE_CR,
    MODE_LF
  } mode_e;

  mode_e                 mode_q;
  logic [1:0]            idx_q;
  logic [2:0]            grp_q;
  logic [LINE_LEN_W-1:0] line_q;
  logic [LINE_LEN_W-1:0] len_q;
  logic                  out_valid_q;
  logic [7:0]            out_char_q;
  logic                  run_last_q;
  logic                  msg_end_q;

  logic                  advance;
  logic                  is_sym;
  logic [4:0]            cur_sym;
  logic [1:0]            idx_n;
  logic [2:0]            grp_n;
  logic [LINE_LEN_W-1:0] line_n;
  logic                  brk;
  logic                  more;
  logic                  final_char;
  logic [7:0]            ch;

  assign out_if.valid       = out_valid_q;
  assign out_if.out_char    = out_char_q;
  assign out_if.run_last    = run_last_q;
  assign out_if.message_end = msg_end_q;

  assign advance = !q_status_i.empty && (!out_valid_q || out_if.ready);
  assign pop_o   = advance && final_char;

  always_comb begin
    is_sym = ({1'b0, idx_q} < {1'b0, head_i.nsym});
    case (idx_q)
      2'd0:    cur_sym = head_i.syms[0];
      2'd1:    cur_sym = head_i.syms[1];
      default: cur_sym = head_i.syms[2];
    endcase
    idx_n  = idx_q + {1'b0, is_sym};
    grp_n  = grp_q + 3'd1;
    line_n = line_q + LINE_LEN_W'(1);
    brk    = (len_q != '0) && (line_n >= len_q);
    more   = 1'b0;
    final_char = 1'b0;
    ch     = CHAR_PAD;
    case (mode_q)
      MODE_ENC: begin
        ch         = is_sym ? sym_to_char(cur_sym) : CHAR_PAD;
        more       = (idx_n < head_i.nsym) || (head_i.last && (grp_n != 3'd0));
        final_char = !brk && !more;
      end
      MODE_CR: begin
        ch = CHAR_CR;
      end
      MODE_LF: begin
        ch         = CHAR_LF;
        more       = is_sym || (head_i.last && (grp_q != 3'd0));
        final_char = !more;
      end
      default: begin
        ch = CHAR_PAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_ENC;
      idx_q       <= '0;
      grp_q       <= '0;
      line_q      <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      run_last_q  <= 1'b0;
      msg_end_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        out_char_q  <= ch;
        run_last_q  <= final_char;
        msg_end_q   <= final_char && head_i.last;
        case (mode_q)
          MODE_ENC: begin
            idx_q <= idx_n;
            grp_q <= grp_n;
            if (len_q != '0) begin
              line_q <= brk ? '0 : line_n;
            end
            mode_q <= brk ? MODE_CR : MODE_ENC;
          end
          MODE_CR: begin
            mode_q <= MODE_LF;
          end
          default: begin
            mode_q <= MODE_ENC;
          end
        endcase
        // drop the request once its last character leaves; a message end also clears the group and line counts
        if (final_char) begin
          idx_q  <= '0;
          mode_q <= MODE_ENC;
          if (head_i.last) begin
            grp_q  <= '0;
            line_q <= '0;
          end
        end
      end
    end
  end

endmodule

>>> rtl/base32_encoder_line_wrap.sv
// Streaming base32 encoder (standard alphabet, MSB first) with optional CR LF
// line breaks every line_length encoded characters; line_length of 0 turns
// breaking off. The front stage takes one byte per cycle while the request queue
// is not full and turns it into one to three symbols (the third is the zero-filled
// flush on a last byte); a small queue holds these requests, and the back sequencer
// writes one character per cycle into the output register while the queue has a
// request and the output register is empty or being taken, adding '=' padding up to
// a multiple of eight encoded characters at message end and CR LF where a line
// fills. A byte yields one to three characters for its symbols (three only with the
// flush of a last byte), two more for each line break, plus the padding at message
// end: about 1.6 characters per byte on long messages. The input stalls only while
// the request queue is full. Write line_length only while the block is idle.
module base32_encoder_line_wrap
  import b32w_pkg::*;
#(
  parameter int unsigned QueueDepth = B32W_QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [LINE_LEN_W-1:0] cfg_wdata_i,
  b32w_in_if.sink               in_if,
  b32w_out_if.source            out_if
);

  logic      push;
  logic      pop;
  sym_req_t  push_req;
  sym_req_t  head;
  q_status_t q_status;

  b32w_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .q_status_i (q_status),
    .push_o     (push),
    .req_o      (push_req)
  );

  b32w_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_req_i (push_req),
    .pop_i      (pop),
    .head_o     (head),
    .status_o   (q_status)
  );

  b32w_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_if      (out_if)
  );

endmodule
